// ===== rtl/rbmf_pkg.sv =====
// rbmf_pkg: shared types, constants and the divide-by-count helper of the box mean filter
`timescale 1ns / 1ps

package rbmf_pkg;

  localparam int CH_W = 8;
  localparam int PIX_W = 3 * CH_W;
  localparam int COL_OUT_W = 11;
  localparam int ROW_W = 12;
  localparam int QUOT_W = 6;
  localparam int SUM_W = 10;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 12;

  localparam int MAX_WIDTH_DEFAULT = 2048;
  localparam int MAX_HEIGHT = 4095;
  localparam int WIDTH_RESET = 640;
  localparam int HEIGHT_RESET = 480;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    DIV_BY_4 = 2'd0,
    DIV_BY_6 = 2'd1,
    DIV_BY_9 = 2'd2
  } div_t;

  // truncating division of one channel by the neighbour count
  function automatic logic [QUOT_W-1:0] quotient(input logic [CH_W-1:0] v, input div_t d);
    logic [17:0] prod;
    logic [QUOT_W-1:0] q;
    prod = 18'd0;
    q = '0;
    case (d)
      DIV_BY_4: begin
        q = v[CH_W-1:2];
      end
      DIV_BY_6: begin
        prod = 18'(v) * 18'd171;
        q = prod[15:10];
      end
      DIV_BY_9: begin
        prod = 18'(v) * 18'd57;
        q = prod[14:9];
      end
      default: begin
        q = '0;
      end
    endcase
    return q;
  endfunction

endpackage

// ===== rtl/rbmf_pixel_if.sv =====
// rbmf_pixel_if: input pixel channel with valid/ready handshake
`timescale 1ns / 1ps

interface rbmf_pixel_if
  import rbmf_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

// ===== rtl/rbmf_result_if.sv =====
// rbmf_result_if: filtered pixel channel with position and run marker
`timescale 1ns / 1ps

interface rbmf_result_if
  import rbmf_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CH_W-1:0]      red_out;
  logic [CH_W-1:0]      green_out;
  logic [CH_W-1:0]      blue_out;
  logic [COL_OUT_W-1:0] out_column;
  logic [ROW_W-1:0]     out_row;
  logic                 last_of_run;

  modport source (
    output valid, output red_out, output green_out, output blue_out,
    output out_column, output out_row, output last_of_run, input ready
  );
  modport sink (
    input valid, input red_out, input green_out, input blue_out,
    input out_column, input out_row, input last_of_run, output ready
  );
endinterface

// ===== rtl/rgb_box_mean_filter_3x3.sv =====
// rgb_box_mean_filter_3x3: streaming 3x3 box mean filter over rgb pixels
//
//   channel   direction  transfer carries
//   pixel     in         red_in, green_in, blue_in of the next raster pixel
//   result    out        red/green/blue_out, out_column, out_row, last_of_run
//   cfg       in         cfg_index selects image_width or image_height, cfg_data
//
// one pixel accepted per clock while the intake is free; a pixel that releases
// results holds it while the emission stage puts them out, one result per cycle
// unless stalled; first results pass stages 1, 2, 3 and the output register
// the two line stores share one single-port-read memory of {upper, lower} words
// rst is synchronous; the line memory needs no clearing pass after reset
// result stalls fill the pipeline and then hold pixel.ready low
`timescale 1ns / 1ps

module rgb_box_mean_filter_3x3
  import rbmf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  rbmf_pixel_if.sink             pixel,
  rbmf_result_if.source          result
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CMP_W = 15;
  localparam int W_RESET = (WIDTH_RESET < MAX_WIDTH) ? WIDTH_RESET : MAX_WIDTH;

  // configuration, kept as last column and last row
  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;
  logic [CMP_W-1:0] w_ext, w_sel;
  logic [ROW_W-1:0] h_sel;
  logic             cfg_hit;

  // raster position
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  // line memory {upper, lower}
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] mem_q;

  // stage 1: waiting for the memory read
  logic             s1_valid;
  logic [PIX_W-1:0] s1_cur;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic [3:0]       s1_mask;
  logic             s1_left, s1_top;
  logic [3:0]       mask_new;

  // stage 2: window and pending results
  logic [PIX_W-1:0] win [9];
  logic [3:0]       s2_mask;
  logic [COL_W-1:0] s2_col;
  logic [ROW_W-1:0] s2_row;
  logic             s2_left, s2_top;
  logic [3:0]       s2_sel, s2_rest;
  logic             s2_busy, s2_issue, s2_take;
  logic             ex_col, ex_row;
  div_t             s2_div;
  logic [QUOT_W-1:0] q_next [3][9];

  // stage 3: quotients
  logic              s3_valid;
  logic [QUOT_W-1:0] s3_q [3][9];
  logic [COL_W-1:0]  s3_col;
  logic [ROW_W-1:0]  s3_row;
  logic              s3_last;
  logic [SUM_W-1:0]  s3_sum [3];

  // output register
  logic out_valid;
  logic [CH_W-1:0] out_ch [3];
  logic [COL_OUT_W-1:0] out_col;
  logic [ROW_W-1:0] out_row_q;
  logic out_last;

  logic in_fire, s1_adv, s1_ready, s3_ready, s3_adv, o_ready;

  assign cfg_hit = cfg_write &&
                   (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  always_comb begin
    w_ext = CMP_W'(cfg_data);
    if (w_ext < CMP_W'(2)) begin
      w_sel = CMP_W'(2);
    end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
      w_sel = CMP_W'(MAX_WIDTH);
    end else begin
      w_sel = w_ext;
    end
    if (cfg_data < ROW_W'(2)) begin
      h_sel = ROW_W'(2);
    end else begin
      h_sel = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= COL_W'(W_RESET - 1);
      h_last <= ROW_W'(HEIGHT_RESET - 1);
    end else if (cfg_write && cfg_index == REG_IMAGE_WIDTH) begin
      w_last <= COL_W'(w_sel - CMP_W'(1));
    end else if (cfg_write && cfg_index == REG_IMAGE_HEIGHT) begin
      h_last <= h_sel - ROW_W'(1);
    end
  end

  // handshake chain
  assign o_ready  = !out_valid || result.ready;
  assign s3_ready = !s3_valid || o_ready;
  assign s3_adv   = s3_valid && o_ready;
  assign s2_busy  = |s2_mask;
  assign s2_issue = s2_busy && s3_ready;
  assign s2_sel   = s2_mask & (~s2_mask + 4'd1);
  assign s2_rest  = s2_mask & ~s2_sel;
  assign s2_take  = !s2_busy || (s2_issue && s2_rest == 4'd0);
  assign s1_adv   = s1_valid && s2_take;
  assign s1_ready = !s1_valid || s1_adv;
  assign pixel.ready = s1_ready;
  assign in_fire  = pixel.valid && s1_ready;

  // raster position
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col <= '0;
      row <= '0;
    end else if (in_fire) begin
      if (col == w_last) begin
        col <= '0;
        row <= (row == h_last) ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // results released: upper-left, upper, left, self
  always_comb begin
    mask_new[0] = (row != '0) && (col != '0);
    mask_new[1] = (row != '0) && (col == w_last);
    mask_new[2] = (row == h_last) && (col != '0);
    mask_new[3] = (row == h_last) && (col == w_last);
  end

  // line memory: read on transfer, write back as the pixel enters the window
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_mem[s1_col] <= {mem_q[PIX_W-1:0], s1_cur};
    end
    if (in_fire) begin
      mem_q <= line_mem[col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cur  <= {pixel.red_in, pixel.green_in, pixel.blue_in};
      s1_col  <= col;
      s1_row  <= row;
      s1_mask <= mask_new;
      s1_left <= (col == COL_W'(1));
      s1_top  <= (row == ROW_W'(1));
    end
  end

  // window shift and pending results
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_mask <= '0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (s1_adv) begin
      s2_mask <= s1_mask;
      for (int k = 0; k < 3; k++) begin
        win[k*3+0] <= win[k*3+1];
        win[k*3+1] <= win[k*3+2];
      end
      win[2] <= mem_q[2*PIX_W-1:PIX_W];
      win[5] <= mem_q[PIX_W-1:0];
      win[8] <= s1_cur;
    end else if (s2_issue) begin
      s2_mask <= s2_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_col  <= s1_col;
      s2_row  <= s1_row;
      s2_left <= s1_left;
      s2_top  <= s1_top;
    end
  end

  // neighbour selection and division for the chosen result
  always_comb begin
    ex_col = (s2_sel[0] || s2_sel[2]) ? s2_left : 1'b1;
    ex_row = (s2_sel[0] || s2_sel[1]) ? s2_top : 1'b1;
    case ({ex_col, ex_row})
      2'b00:   s2_div = DIV_BY_9;
      2'b11:   s2_div = DIV_BY_4;
      default: s2_div = DIV_BY_6;
    endcase
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 9; i++) begin
        if ((ex_row && i < 3) || (ex_col && (i % 3) == 0)) begin
          q_next[ch][i] = '0;
        end else begin
          q_next[ch][i] = quotient(win[i][PIX_W-1-CH_W*ch -: CH_W], s2_div);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s2_issue) begin
      s3_valid <= 1'b1;
    end else if (s3_adv) begin
      s3_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_issue) begin
      s3_q    <= q_next;
      s3_col  <= (s2_sel[0] || s2_sel[2]) ? s2_col - COL_W'(1) : s2_col;
      s3_row  <= (s2_sel[0] || s2_sel[1]) ? s2_row - ROW_W'(1) : s2_row;
      s3_last <= (s2_rest == 4'd0);
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      s3_sum[ch] = '0;
      for (int i = 0; i < 9; i++) begin
        s3_sum[ch] = s3_sum[ch] + SUM_W'(s3_q[ch][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        out_ch[ch] <= (s3_sum[ch] > SUM_W'(255)) ? CH_W'(255) : s3_sum[ch][CH_W-1:0];
      end
      out_col   <= COL_OUT_W'(s3_col);
      out_row_q <= s3_row;
      out_last  <= s3_last;
    end
  end

  assign result.valid       = out_valid;
  assign result.red_out     = out_ch[0];
  assign result.green_out   = out_ch[1];
  assign result.blue_out    = out_ch[2];
  assign result.out_column  = out_col;
  assign result.out_row     = out_row_q;
  assign result.last_of_run = out_last;

  // pending results never belong to the top row's pixels
  a_no_top_row_results: assert property (@(posedge clk) disable iff (rst)
    (s2_mask != 4'd0) |-> (s2_row != '0))
    else $error("results pending for a pixel on row 0");

  // write-back and a new read never hit the same column
  a_no_mem_collision: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s1_adv) |-> (col != s1_col))
    else $error("line memory read and write at the same column");

  // quotient sums stay in range
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (s3_sum[0] <= SUM_W'(252) && s3_sum[1] <= SUM_W'(252) &&
                  s3_sum[2] <= SUM_W'(252)))
    else $error("mean sum out of range");

  // column counter stays inside the configured row
  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (col <= w_last))
    else $error("column position beyond last column");

endmodule
